@@ src/fdrd_pkg.sv @@
package fdrd_pkg;

   localparam int WORD_W      = 32;
   localparam int CFG_W       = 10;
   localparam int REG_IDX_W   = 1;
   localparam int FIRST_ROW_W = 9;
   localparam int END_ROW_W   = 10;

   localparam logic [REG_IDX_W-1:0] REG_ROW_WORDS  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

   localparam logic [CFG_W-1:0] ROW_WORDS_RESET  = 10'd512;
   localparam logic [CFG_W-1:0] FRAME_ROWS_RESET = 10'd512;

   typedef struct packed {
      logic last_col;
      logic last_row;
   } fdrd_pos_type;

endpackage

@@ src/fdrd_ram.sv @@
module fdrd_ram
   #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fdrd_addr_gen.sv @@
module fdrd_addr_gen
   import fdrd_pkg::*;
   #(
   parameter int MAX_ROW_WORDS = 512,
   parameter int MAX_ROWS      = 512,
   parameter int DEPTH         = MAX_ROW_WORDS * MAX_ROWS,
   parameter int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int COL_W         = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1,
   parameter int ROW_W         = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
   )
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CFG_W-1:0]  row_words,
   input  logic [CFG_W-1:0]  frame_rows,
   output logic [ADDR_W-1:0] addr,
   output logic [ROW_W-1:0]  row,
   output logic [ROW_W-1:0]  rows_m1,
   output fdrd_pos_type      pos
   );

   localparam int RWW  = $clog2(MAX_ROW_WORDS + 1);
   localparam int RRW  = $clog2(MAX_ROWS + 1);
   localparam int EW   = RWW + RRW + CFG_W + 2;
   localparam int MULW = COL_W + ROW_W + RWW + 2;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [EW-1:0]    rw_x, rows_x;
   logic [RWW-1:0]   rw;
   logic [RRW-1:0]   rows;
   logic [MULW-1:0]  addr_full;

   always_comb begin
      if (row_words == '0) begin
         rw_x = EW'(1);
      end else if (EW'(row_words) > EW'(MAX_ROW_WORDS)) begin
         rw_x = EW'(MAX_ROW_WORDS);
      end else begin
         rw_x = EW'(row_words);
      end
      if (frame_rows == '0) begin
         rows_x = EW'(1);
      end else if (EW'(frame_rows) > EW'(MAX_ROWS)) begin
         rows_x = EW'(MAX_ROWS);
      end else begin
         rows_x = EW'(frame_rows);
      end
   end

   assign rw      = RWW'(rw_x);
   assign rows    = RRW'(rows_x);
   assign rows_m1 = ROW_W'(EW'(rows) - EW'(1));

   assign pos.last_col = (EW'(col_ff) + EW'(1)) >= EW'(rw);
   assign pos.last_row = (EW'(row_ff) + EW'(1)) >= EW'(rows);

   assign addr_full = MULW'(row_ff) * MULW'(rw) + MULW'(col_ff);
   assign addr      = ADDR_W'(addr_full);
   assign row       = row_ff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (!pos.last_col) begin
            col_in = COL_W'(EW'(col_ff) + EW'(1));
         end else begin
            col_in = '0;
            if (!pos.last_row) begin
               row_in = ROW_W'(EW'(row_ff) + EW'(1));
            end else begin
               row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ src/fdrd_dirty_track.sv @@
module fdrd_dirty_track
   import fdrd_pkg::*;
   #(
   parameter int ROW_W = 9
   )
   (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   differ,
   input  logic                   frame_end,
   input  logic [ROW_W-1:0]       row,
   input  logic [ROW_W-1:0]       rows_m1,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_changed,
   output logic [FIRST_ROW_W-1:0] rsp_first_row,
   output logic [END_ROW_W-1:0]   rsp_end_row
   );

   localparam int XW = ROW_W + END_ROW_W + 1;

   logic             any_ff, any_in;
   logic [ROW_W-1:0] first_ff, first_in;
   logic [ROW_W-1:0] last_ff, last_in;
   logic             rsp_valid_ff;
   logic             changed_ff;
   logic [FIRST_ROW_W-1:0] first_row_ff;
   logic [END_ROW_W-1:0]   end_row_ff;
   logic [XW-1:0]    first_x, end_x;

   always_comb begin
      any_in   = any_ff;
      first_in = first_ff;
      last_in  = last_ff;
      if (differ) begin
         any_in  = 1'b1;
         last_in = row;
         if (!any_ff) begin
            first_in = row;
         end
      end
      if (any_in) begin
         first_x = XW'(first_in);
         end_x   = XW'(last_in) + XW'(1);
      end else begin
         first_x = XW'(rows_m1);
         end_x   = XW'(rows_m1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff       <= 1'b0;
         first_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            if (frame_end) begin
               any_ff   <= 1'b0;
               first_ff <= '0;
               last_ff  <= '0;
            end else begin
               any_ff   <= any_in;
               first_ff <= first_in;
               last_ff  <= last_in;
            end
         end
         if (step && frame_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && frame_end) begin
         changed_ff   <= any_in;
         first_row_ff <= first_x[FIRST_ROW_W-1:0];
         end_row_ff   <= end_x[END_ROW_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_changed   = changed_ff;
   assign rsp_first_row = first_row_ff;
   assign rsp_end_row   = end_row_ff;

endmodule

@@ src/frame_dirty_row_detector_unit.sv @@
// channel  ports                                                          dir
// req      req_valid, req_stall, req_pixel_word                           in
// rsp      rsp_valid, rsp_stall, rsp_changed, rsp_first_row, rsp_end_row  out
// csr      csr_wr_en, csr_index, csr_wdata                                in
//
// one word per cycle unless req_stall is high; one frame memory read and one write per cycle
// the result is registered once the last word of a frame has passed stages s1 and s2
// after reset the frame memory is zeroed one word a cycle, all MAX_ROW_WORDS * MAX_ROWS
// words (262144 at the defaults); req_stall stays high meanwhile
// a waiting result holds the pipe only when the next frame end reaches it
module frame_dirty_row_detector_unit
   import fdrd_pkg::*;
   #(
   parameter int MAX_ROW_WORDS = 512,
   parameter int MAX_ROWS      = 512
   )
   (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WORD_W-1:0]      req_pixel_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_changed,
   output logic [FIRST_ROW_W-1:0] rsp_first_row,
   output logic [END_ROW_W-1:0]   rsp_end_row,
   input  logic                   csr_wr_en,
   input  logic [REG_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
   );

   localparam int DEPTH  = MAX_ROW_WORDS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [CFG_W-1:0]  row_words_ff, frame_rows_ff;
   logic              clear_ff;
   logic [ADDR_W-1:0] clear_cnt_ff;

   logic              adv, accept;
   logic [ADDR_W-1:0] gen_addr;
   logic [ROW_W-1:0]  gen_row, gen_rows_m1;
   fdrd_pos_type      gen_pos;

   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [WORD_W-1:0] s1_word_ff;
   logic [ROW_W-1:0]  s1_row_ff, s1_rows_m1_ff;
   logic              s1_final_ff;

   logic              s2_valid_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [WORD_W-1:0] s2_word_ff;
   logic [ROW_W-1:0]  s2_row_ff, s2_rows_m1_ff;
   logic              s2_final_ff;
   logic              bypass_ff;
   logic [WORD_W-1:0] bypass_word_ff;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [WORD_W-1:0] ram_rd_data;
   logic [WORD_W-1:0] prev_word;
   logic              differ;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_words_ff  <= ROW_WORDS_RESET;
         frame_rows_ff <= FRAME_ROWS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROW_WORDS: begin
               row_words_ff <= csr_wdata;
            end
            REG_FRAME_ROWS: begin
               frame_rows_ff <= csr_wdata;
            end
         endcase
      end
   end

   // memory clear after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clear_ff) begin
         if (clear_cnt_ff == ADDR_W'(DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
         clear_cnt_ff <= clear_cnt_ff + ADDR_W'(1);
      end
   end

   assign adv       = !(s2_valid_ff && s2_final_ff && rsp_valid && rsp_stall);
   assign req_stall = clear_ff || !adv;
   assign accept    = req_valid && !req_stall;

   fdrd_addr_gen #(
      .MAX_ROW_WORDS (MAX_ROW_WORDS),
      .MAX_ROWS      (MAX_ROWS)
   ) u_addr_gen (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .row_words  (row_words_ff),
      .frame_rows (frame_rows_ff),
      .addr       (gen_addr),
      .row        (gen_row),
      .rows_m1    (gen_rows_m1),
      .pos        (gen_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff     <= gen_addr;
         s1_word_ff     <= req_pixel_word;
         s1_row_ff      <= gen_row;
         s1_rows_m1_ff  <= gen_rows_m1;
         s1_final_ff    <= gen_pos.last_col && gen_pos.last_row;
         s2_addr_ff     <= s1_addr_ff;
         s2_word_ff     <= s1_word_ff;
         s2_row_ff      <= s1_row_ff;
         s2_rows_m1_ff  <= s1_rows_m1_ff;
         s2_final_ff    <= s1_final_ff;
         // older transaction writes the same word at this edge
         bypass_ff      <= s1_valid_ff && s2_valid_ff && (s1_addr_ff == s2_addr_ff);
         bypass_word_ff <= s2_word_ff;
      end
   end

   always_comb begin
      if (clear_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = adv && s2_valid_ff;
         ram_wr_addr = s2_addr_ff;
         ram_wr_data = s2_word_ff;
      end
   end

   fdrd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (adv),
      .rd_addr (s1_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign prev_word = bypass_ff ? bypass_word_ff : ram_rd_data;
   assign differ    = prev_word != s2_word_ff;

   fdrd_dirty_track #(
      .ROW_W (ROW_W)
   ) u_dirty_track (
      .clock         (clock),
      .reset         (reset),
      .step          (adv && s2_valid_ff),
      .differ        (differ),
      .frame_end     (s2_final_ff),
      .row           (s2_row_ff),
      .rows_m1       (s2_rows_m1_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_changed   (rsp_changed),
      .rsp_first_row (rsp_first_row),
      .rsp_end_row   (rsp_end_row)
   );

endmodule
